[hdl/mpv_pkg.sv]
package mpv_pkg;

	localparam int MAX_DEPTH_DEFAULT = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_HASH_KIND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_WORD0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_WORD1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_WORD2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_WORD3 = 3'd4;

	localparam logic OP_LEAF = 1'b0;
	localparam logic OP_SIBLING = 1'b1;

	localparam logic HASH_SHA256 = 1'b0;
	localparam logic HASH_MD5 = 1'b1;

	localparam logic [1:0] ST_MATCH = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_TOO_DEEP = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [1:0]  word_index;
		logic [63:0] digest_word;
		logic        sibling_left;
		logic        last_of_proof;
	} in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] siblings_applied;
	} out_t;

	typedef logic [3:0][63:0] digest_t;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] MD5_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] MD5_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

endpackage

[hdl/merkle_proof_verifier_core.sv]
// Merkle inclusion proof checker. Feed the leaf digest words, then the words
// of each sibling on the path, as 64-bit words with the first byte in the
// top bits; the flag on a sibling's last word sets whether it is hashed
// first. A word that ends neither a sibling nor the proof leaves the block
// idle and ready for the next word. The word that completes a sibling, while
// the depth limit is not yet reached, starts one shared round unit that does
// one round per cycle: SHA-256 needs two compression blocks, each of 64 rounds
// and an add step, between a load and a hand-back; MD5 needs one block. The
// block holds off input (stall high) until the fold has finished. On the word
// marked last of proof, one result transfer reports match, mismatch or too
// deep; out_valid rises from the finish state, entered straight from that
// word or once the fold it caused ends, and the proof state clears for the
// next proof. The result sits in an output register; input is also held off
// while that register is still full and stalled.
module merkle_proof_verifier_core #(
	parameter int MAX_DEPTH = mpv_pkg::MAX_DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mpv_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output mpv_pkg::out_t                   out_data,
	input  logic                            cfg_we,
	input  logic [mpv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                     cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_HASH = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t                       state_q;
	logic                         hash_kind_q;
	mpv_pkg::digest_t             root_q;
	mpv_pkg::digest_t             running_q;
	mpv_pkg::digest_t             sibling_q;
	logic                         side_q;
	logic [mpv_pkg::CNT_W-1:0]    count_q;
	logic                         overflow_q;
	logic                         last_q;
	logic                         out_valid_q;
	mpv_pkg::out_t                out_q;

	logic                         in_fire;
	logic                         word_in_range;
	logic                         completes;
	logic                         core_start;
	logic                         core_done;
	mpv_pkg::digest_t             core_digest;
	mpv_pkg::digest_t             first_d;
	mpv_pkg::digest_t             second_d;
	logic [511:0]                 block;
	logic                         same;

	// hold input while the fold runs or reports, or a result still waits
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_fire = in_valid && !in_stall;

	// MD5 digests are two words, SHA-256 four
	assign word_in_range = (hash_kind_q == mpv_pkg::HASH_MD5) ?
		(in_data.word_index < 2'd2) : 1'b1;
	assign completes = word_in_range && (in_data.opcode == mpv_pkg::OP_SIBLING) &&
		(in_data.word_index == ((hash_kind_q == mpv_pkg::HASH_MD5) ? 2'd1 : 2'd3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_kind_q <= mpv_pkg::HASH_SHA256;
			root_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpv_pkg::REG_HASH_KIND: hash_kind_q <= cfg_data[0];
				mpv_pkg::REG_ROOT_WORD0: root_q[0] <= cfg_data;
				mpv_pkg::REG_ROOT_WORD1: root_q[1] <= cfg_data;
				mpv_pkg::REG_ROOT_WORD2: root_q[2] <= cfg_data;
				mpv_pkg::REG_ROOT_WORD3: root_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// order the pair into one block, padded for MD5; the hash unit adds its own
	// second block for SHA-256
	always_comb begin
		first_d = side_q ? sibling_q : running_q;
		second_d = side_q ? running_q : sibling_q;
		if (hash_kind_q == mpv_pkg::HASH_MD5) begin
			block = {first_d[0], first_d[1], second_d[0], second_d[1],
				64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h0001_0000_0000_0000};
		end else begin
			block = {first_d[0], first_d[1], first_d[2], first_d[3],
				second_d[0], second_d[1], second_d[2], second_d[3]};
		end
	end

	assign core_start = (state_q == S_LOAD);

	mpv_hash_unit u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (core_start),
		.md5_mode (hash_kind_q),
		.block    (block),
		.done     (core_done),
		.digest   (core_digest)
	);

	always_comb begin
		same = (running_q[0] == root_q[0]) && (running_q[1] == root_q[1]);
		if (hash_kind_q == mpv_pkg::HASH_SHA256) begin
			same = same && (running_q[2] == root_q[2]) && (running_q[3] == root_q[3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			running_q <= '0;
			side_q <= 1'b0;
			count_q <= '0;
			overflow_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						last_q <= in_data.last_of_proof;
						if (word_in_range && in_data.opcode == mpv_pkg::OP_LEAF) begin
							running_q[in_data.word_index] <= in_data.digest_word;
						end
						if (word_in_range && in_data.opcode == mpv_pkg::OP_SIBLING) begin
							side_q <= in_data.sibling_left;
						end
						if (completes && count_q < mpv_pkg::CNT_W'(MAX_DEPTH)) begin
							state_q <= S_LOAD;
						end else begin
							if (completes) begin
								overflow_q <= 1'b1;
							end
							if (in_data.last_of_proof) begin
								state_q <= S_FIN;
							end
						end
					end
				end
				S_LOAD: begin
					state_q <= S_HASH;
				end
				S_HASH: begin
					if (core_done) begin
						running_q <= core_digest;
						count_q <= count_q + mpv_pkg::CNT_W'(1);
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				default: begin
					// report, then clear the proof state
					out_valid_q <= 1'b1;
					running_q <= '0;
					side_q <= 1'b0;
					count_q <= '0;
					overflow_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_fire && word_in_range &&
			in_data.opcode == mpv_pkg::OP_SIBLING) begin
			sibling_q[in_data.word_index] <= in_data.digest_word;
		end
		if (state_q == S_FIN) begin
			out_q.siblings_applied <= count_q;
			if (overflow_q) begin
				out_q.status <= mpv_pkg::ST_TOO_DEEP;
			end else if (same) begin
				out_q.status <= mpv_pkg::ST_MATCH;
			end else begin
				out_q.status <= mpv_pkg::ST_MISMATCH;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

[hdl/mpv_hash_unit.sv]
module mpv_hash_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 md5_mode,
	input  logic [511:0]         block,
	output logic                 done,
	output mpv_pkg::digest_t     digest
);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_ADD  = 3'b100
	} cstate_t;

	cstate_t            cst_q;
	logic [7:0][31:0]   v_q;
	logic [7:0][31:0]   h_q;
	logic [15:0][31:0]  win_q;
	logic [5:0]         rnd_q;
	logic               second_q;
	logic               mode_q;
	logic               done_q;

	logic [15:0][31:0]  blk_words;
	logic [15:0][31:0]  pad_words;
	logic [7:0][31:0]   sha_iv;
	logic [7:0][31:0]   hsum;
	logic [7:0][31:0]   v_next;
	logic [15:0][31:0]  win_next;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] x);
		bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			blk_words[i] = md5_mode ? bswap(block[511-32*i -: 32]) : block[511-32*i -: 32];
			pad_words[i] = 32'h0;
		end
		pad_words[0] = 32'h8000_0000;
		pad_words[15] = 32'h0000_0200;
		sha_iv = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
			32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};
		for (int i = 0; i < 8; i++) begin
			hsum[i] = h_q[i] + v_q[i];
		end
	end

	// one round of whichever hash is running
	always_comb begin
		logic [31:0] s0, s1, ch, maj, t1, t2, w16;
		logic [31:0] f, f1, msg;
		logic [63:0] rot;
		logic [3:0]  g;
		logic [3:0]  sidx;
		v_next = v_q;
		win_next = win_q;
		s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + mpv_pkg::SHA_K[rnd_q] + win_q[0];
		s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0 + maj;
		w16 = win_q[0] + (rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3))
			+ win_q[9] + (rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10));
		unique case (rnd_q[5:4])
			2'd0: begin
				f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
				g = rnd_q[3:0];
			end
			2'd1: begin
				f = (v_q[3] & v_q[1]) | (~v_q[3] & v_q[2]);
				g = rnd_q[3:0] * 4'd5 + 4'd1;
			end
			2'd2: begin
				f = v_q[1] ^ v_q[2] ^ v_q[3];
				g = rnd_q[3:0] * 4'd3 + 4'd5;
			end
			default: begin
				f = v_q[2] ^ (v_q[1] | ~v_q[3]);
				g = rnd_q[3:0] * 4'd7;
			end
		endcase
		msg = win_q[g];
		sidx = {rnd_q[5:4], rnd_q[1:0]};
		f1 = f + v_q[0] + mpv_pkg::MD5_K[rnd_q] + msg;
		rot = {f1, f1} << mpv_pkg::MD5_S[sidx];
		if (mode_q) begin
			v_next[0] = v_q[3];
			v_next[3] = v_q[2];
			v_next[2] = v_q[1];
			v_next[1] = v_q[1] + rot[63:32];
		end else begin
			v_next = {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
			win_next = {w16, win_q[15:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q <= C_IDLE;
			done_q <= 1'b0;
			rnd_q <= '0;
			second_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (cst_q)
				C_IDLE: begin
					if (start) begin
						cst_q <= C_RUN;
						rnd_q <= '0;
						second_q <= 1'b0;
					end
				end
				C_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						cst_q <= C_ADD;
					end
				end
				default: begin
					rnd_q <= '0;
					if (!mode_q && !second_q) begin
						second_q <= 1'b1;
						cst_q <= C_RUN;
					end else begin
						done_q <= 1'b1;
						cst_q <= C_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cst_q)
			C_IDLE: begin
				if (start) begin
					mode_q <= md5_mode;
					win_q <= blk_words;
					if (md5_mode) begin
						h_q <= {128'h0, 32'h10325476, 32'h98badcfe, 32'hefcdab89,
							32'h67452301};
						v_q <= {128'h0, 32'h10325476, 32'h98badcfe, 32'hefcdab89,
							32'h67452301};
					end else begin
						h_q <= sha_iv;
						v_q <= sha_iv;
					end
				end
			end
			C_RUN: begin
				v_q <= v_next;
				win_q <= win_next;
			end
			default: begin
				h_q <= hsum;
				v_q <= hsum;
				win_q <= pad_words;
			end
		endcase
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			digest[j] = {h_q[2*j], h_q[2*j+1]};
		end
		if (mode_q) begin
			digest[0] = {bswap(h_q[0]), bswap(h_q[1])};
			digest[1] = {bswap(h_q[2]), bswap(h_q[3])};
			digest[2] = 64'h0;
			digest[3] = 64'h0;
		end
	end

	assign done = done_q;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_DEPTH = mpv_pkg::MAX_DEPTH_DEFAULT;
	localparam int SETTLE_CYCLES = 200; // longer than one SHA-256 fold plus output slack

	// Path state of one proof, held by the predictor
	typedef struct {
		mpv_pkg::digest_t run;
		mpv_pkg::digest_t sib;
		bit               side;
		int unsigned      count;
		bit               ovf;
	} proof_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	mpv_pkg::in_t                  in_data;
	logic                          out_valid;
	logic                          out_stall;
	mpv_pkg::out_t                 out_data;
	logic                          cfg_we;
	logic [mpv_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0]                   cfg_data;

	merkle_proof_verifier_core #(.MAX_DEPTH(MAX_DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ---------------------------------------------------------------
	// Hash cores for the predictor
	// ---------------------------------------------------------------
	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bswap32(logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic [0:7][31:0] sha_block(logic [0:7][31:0] st, logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = blk[511 - 32*i -: 32];
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = st[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + mpv_pkg::SHA_K[i] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			st[i] = st[i] + v[i];
		return st;
	endfunction

	function automatic logic [0:3][31:0] md5_block(logic [0:3][31:0] st, logic [511:0] blk);
		logic [31:0] m [16];
		logic [31:0] a, b, c, d, f, tmp;
		int g, k;
		for (int i = 0; i < 16; i++)
			m[i] = bswap32(blk[511 - 32*i -: 32]);
		a = st[0]; b = st[1]; c = st[2]; d = st[3];
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = (b & c) | (~b & d); g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & c); g = (5*i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ c ^ d; g = (3*i + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7*i) % 16;
			end
			f = f + a + mpv_pkg::MD5_K[i] + m[g];
			k = mpv_pkg::MD5_S[((i >> 4) << 2) | (i & 3)];
			tmp = d; d = c; c = b;
			b = b + ((f << k) | (f >> (32 - k)));
			a = tmp;
		end
		st[0] += a; st[1] += b; st[2] += c; st[3] += d;
		return st;
	endfunction

	function automatic proof_t clean_proof();
		proof_t p;
		p.run = '0;
		p.sib = '0;
		p.side = 1'b0;
		p.count = 0;
		p.ovf = 1'b0;
		return p;
	endfunction

	// Replace the running digest by the hash of the ordered pair
	function automatic void fold_pair(inout proof_t p, input logic hk);
		mpv_pkg::digest_t a, b;
		logic [0:7][31:0] hs;
		logic [0:3][31:0] hm;
		a = p.side ? p.sib : p.run;
		b = p.side ? p.run : p.sib;
		if (hk == mpv_pkg::HASH_SHA256) begin
			hs = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
			hs = sha_block(hs, {a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3]});
			hs = sha_block(hs, {8'h80, 488'h0, 16'h0200});
			for (int j = 0; j < 4; j++)
				p.run[j] = {hs[2*j], hs[2*j+1]};
		end else begin
			hm = {32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
			hm = md5_block(hm, {a[0], a[1], b[0], b[1], 8'h80, 192'h0, 8'h01, 48'h0});
			p.run[0] = {bswap32(hm[0]), bswap32(hm[1])};
			p.run[1] = {bswap32(hm[2]), bswap32(hm[3])};
			p.run[2] = '0;
			p.run[3] = '0;
		end
	endfunction

	// Advance the path state by one word; returns 1 when the word ends the proof
	function automatic bit advance_proof(inout proof_t p, input logic hk,
			input mpv_pkg::digest_t root, input mpv_pkg::in_t x, output mpv_pkg::out_t r);
		int nw;
		bit same;
		nw = (hk == mpv_pkg::HASH_MD5) ? 2 : 4;
		r = '0;
		if (x.word_index < nw) begin
			if (x.opcode == mpv_pkg::OP_LEAF) begin
				p.run[x.word_index] = x.digest_word;
			end else begin
				p.sib[x.word_index] = x.digest_word;
				p.side = x.sibling_left;
				if (x.word_index == nw - 1) begin
					if (p.count < MAX_DEPTH) begin
						fold_pair(p, hk);
						p.count++;
					end else begin
						p.ovf = 1'b1;
					end
				end
			end
		end
		if (!x.last_of_proof)
			return 1'b0;
		same = 1'b1;
		for (int j = 0; j < nw; j++)
			if (p.run[j] != root[j])
				same = 1'b0;
		r.status = p.ovf ? mpv_pkg::ST_TOO_DEEP :
			(same ? mpv_pkg::ST_MATCH : mpv_pkg::ST_MISMATCH);
		r.siblings_applied = p.count[mpv_pkg::CNT_W-1:0];
		p = clean_proof();
		return 1'b1;
	endfunction

	class proof_board;
		proof_t           st;
		logic             hk;
		mpv_pkg::digest_t root;
		mpv_pkg::out_t    due[$];
		int               errors;

		function new();
			st = clean_proof();
			hk = mpv_pkg::HASH_SHA256;
			root = '0;
			errors = 0;
		endfunction

		function void note(mpv_pkg::in_t x);
			mpv_pkg::out_t r;
			if (advance_proof(st, hk, root, x, r))
				due = {due, r};
		endfunction

		function void check(mpv_pkg::out_t got);
			mpv_pkg::out_t exp;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status=%0d applied=%0d",
					$time, got.status, got.siblings_applied);
				return;
			end
			exp = due.pop_front();
			if (got.status !== exp.status) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
			end
			if (got.siblings_applied !== exp.siblings_applied) begin
				errors++;
				$display("%0t: siblings_applied expected %0d actual %0d",
					$time, exp.siblings_applied, got.siblings_applied);
			end
		endfunction
	endclass

	proof_board sb = new();

	int send_pct;
	int stall_pct;
	bit hold_req;
	int hold_left;
	int sent;

	// ---------------------------------------------------------------
	// Result side: random stall plus the long hold-off on request
	// ---------------------------------------------------------------
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
			if (hold_left > 0)
				hold_left--;
		end
	end

	// Compare every result transfer against the oldest expectation
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check(out_data);

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------
	task automatic send_word(mpv_pkg::in_t x);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		do @(posedge clk); while (in_stall);
		sb.note(x);
		sent++;
	endtask

	task automatic send_all(ref mpv_pkg::in_t q[$], input int from, input int upto);
		for (int i = from; i < upto; i++)
			send_word(q[i]);
	endtask

	// Hold the input quiet until no result is outstanding and any fold is done
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic hk_v, mpv_pkg::digest_t r);
		cfg_we <= 1'b1;
		cfg_index <= mpv_pkg::REG_HASH_KIND;
		cfg_data <= {63'b0, hk_v};
		@(posedge clk);
		for (int j = 0; j < 4; j++) begin
			cfg_index <= mpv_pkg::REG_ROOT_WORD0 + mpv_pkg::CFG_IDX_W'(j);
			cfg_data <= r[j];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		sb.hk = hk_v;
		sb.root = r;
	endtask

	function automatic logic [63:0] pick_word(bit extreme);
		if (extreme)
			return $urandom_range(1) ? '1 : '0;
		return {$urandom, $urandom};
	endfunction

	// Append one proof: leaf words, then each sibling ending on its last word.
	// Noisy proofs add dropped words, leaf rewrites and odd closing words.
	function automatic void build_proof(logic hk, int nsib, bit extreme, bit noisy,
			ref mpv_pkg::in_t q[$]);
		int nw, start;
		int order[$];
		mpv_pkg::in_t x;
		nw = (hk == mpv_pkg::HASH_MD5) ? 2 : 4;
		start = q.size();
		x = '0;
		if (!noisy || $urandom_range(3) != 0) begin
			order = {};
			for (int j = 0; j < nw; j++)
				order = {order, j};
			order.shuffle();
			foreach (order[j]) begin
				x.opcode = mpv_pkg::OP_LEAF;
				x.word_index = 2'(order[j]);
				x.digest_word = pick_word(extreme);
				x.sibling_left = 1'($urandom_range(1));
				q = {q, x};
			end
		end
		for (int s = 0; s < nsib; s++) begin
			order = {};
			for (int j = 0; j < nw - 1; j++)
				order = {order, j};
			order.shuffle();
			foreach (order[j]) begin
				x.opcode = mpv_pkg::OP_SIBLING;
				x.word_index = 2'(order[j]);
				x.digest_word = pick_word(extreme);
				x.sibling_left = 1'($urandom_range(1));
				q = {q, x};
			end
			if (noisy && hk == mpv_pkg::HASH_MD5) begin
				x.opcode = 1'($urandom_range(1));
				x.word_index = 2'($urandom_range(3, 2));
				x.digest_word = pick_word(extreme);
				q = {q, x};
			end
			if (noisy && $urandom_range(2) == 0) begin
				x.opcode = mpv_pkg::OP_LEAF;
				x.word_index = 2'($urandom_range(nw - 1));
				x.digest_word = pick_word(extreme);
				q = {q, x};
			end
			x.opcode = mpv_pkg::OP_SIBLING;
			x.word_index = 2'(nw - 1);
			x.digest_word = pick_word(extreme);
			x.sibling_left = 1'($urandom_range(1));
			q = {q, x};
		end
		if ((noisy && $urandom_range(1)) || q.size() == start) begin
			x.opcode = 1'($urandom_range(1));
			x.word_index = (hk == mpv_pkg::HASH_MD5) ? 2'($urandom_range(3, 2)) :
				2'($urandom_range(3));
			if (hk == mpv_pkg::HASH_SHA256)
				x.opcode = mpv_pkg::OP_LEAF;
			x.digest_word = pick_word(extreme);
			q = {q, x};
		end
		q[q.size() - 1].last_of_proof = 1'b1;
	endfunction

	// Running digest that the given words would leave, without ending the proof
	function automatic mpv_pkg::digest_t digest_after(ref mpv_pkg::in_t q[$], input logic hk,
			input int upto);
		proof_t p;
		mpv_pkg::out_t r;
		mpv_pkg::in_t x;
		p = sb.st;
		for (int i = 0; i < upto; i++) begin
			x = q[i];
			x.last_of_proof = 1'b0;
			void'(advance_proof(p, hk, sb.root, x, r));
		end
		return p.run;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		mpv_pkg::in_t q[$];
		mpv_pkg::digest_t root;
		logic hk;
		int ph, n_proofs, first_end, nsib;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = mpv_pkg::REG_HASH_KIND;
		cfg_data = '0;
		send_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: SHA-256 proof with extreme words, root set to match
		q = {};
		build_proof(mpv_pkg::HASH_SHA256, 2, 1'b1, 1'b0, q);
		write_cfg(mpv_pkg::HASH_SHA256, digest_after(q, mpv_pkg::HASH_SHA256, q.size()));
		send_all(q, 0, q.size());
		drain();

		// Directed: noisy MD5 proof with random noise words, root set to match
		q = {};
		build_proof(mpv_pkg::HASH_MD5, 2, 1'b0, 1'b1, q);
		write_cfg(mpv_pkg::HASH_MD5, digest_after(q, mpv_pkg::HASH_MD5, q.size()));
		send_all(q, 0, q.size());
		drain();

		// Directed: hash changes in the middle of a proof
		q = {};
		build_proof(mpv_pkg::HASH_SHA256, 1, 1'b0, 1'b0, q);
		q[q.size() - 1].last_of_proof = 1'b0;
		send_all(q, 0, q.size());
		drain();
		q = {};
		build_proof(mpv_pkg::HASH_MD5, 1, 1'b0, 1'b0, q);
		write_cfg(mpv_pkg::HASH_MD5, {{$urandom, $urandom}, 64'h0,
			64'hffff_ffff_ffff_ffff, {$urandom, $urandom}});
		send_all(q, 0, q.size());
		drain();

		// Random phases, cycling through the idling patterns
		ph = 0;
		while (sent < 820) begin
			case (ph % 4)
				0: begin send_pct = 0;  stall_pct = 0;  end
				1: begin send_pct = 80; stall_pct = 0;  end
				2: begin send_pct = 0;  stall_pct = 80; end
				default: begin send_pct = 27; stall_pct = 27; end
			endcase
			hk = (ph < 2) ? ph[0] : logic'($urandom_range(1));
			q = {};
			n_proofs = $urandom_range(6, 3);
			first_end = 0;
			for (int k = 0; k < n_proofs; k++) begin
				if ($urandom_range(19) == 0 || ph == 3)
					nsib = $urandom_range(MAX_DEPTH + 3, MAX_DEPTH - 1);
				else
					nsib = $urandom_range(4);
				build_proof(hk, nsib, $urandom_range(7) == 0, $urandom_range(2) == 0, q);
				if (k == 0)
					first_end = q.size();
			end
			case ($urandom_range(3))
				0: root = {{$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}};
				1: root = '1;
				2: root = '0;
				default: root = digest_after(q, hk, first_end);
			endcase
			if (ph == 1)
				root = '1;
			write_cfg(hk, root);
			if (ph == 5)
				hold_req = 1'b1;
			send_all(q, 0, q.size() / 2);
			if (ph == 6) begin
				// pause the sender until everything outstanding has come back
				in_valid <= 1'b0;
				while (sb.due.size() != 0)
					@(posedge clk);
			end
			send_all(q, q.size() / 2, q.size());
			drain();
			ph++;
		end

		stall_pct = 0;
		if (sb.errors == 0 && sb.due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
hdl/mpv_pkg.sv
hdl/mpv_hash_unit.sv
hdl/merkle_proof_verifier_core.sv
dv/tb_top.sv
